FILE: rtl/core/rqa_pkg.sv
// ----------------------------------------------------------------------------
// rqa_pkg: running quaternion average, shared definitions
// Widths, status codes, control word layout and the microprogram ROM.
// ----------------------------------------------------------------------------
package rqa_pkg;

  localparam int FracBits = 14;
  localparam int NewW     = 16;              // input component width
  localparam int CntW     = 11;              // sample count width
  localparam int SumW     = 27;              // kept sum width
  localparam int OpW      = SumW + 1;        // multiplier operand width
  localparam int ProdW    = 2 * OpW;         // product / accumulator width
  localparam int RootW    = ProdW / 2;       // square root width
  localparam int RemW     = RootW + 1;       // root and divide remainder width
  localparam int QW       = FracBits + 1;    // quotient width
  localparam int NumW     = SumW + QW;       // dividend width
  localparam int StatW    = 2;
  localparam int Lanes    = 4;
  localparam int LaneW    = 2;
  localparam int PcW      = 5;
  localparam int ImmW     = 5;
  localparam int SqrtIters = RootW - 1;      // loop count, one root bit a step
  localparam int DivIters  = QW - 1;         // loop count, one quotient bit a step

  localparam logic [QW-1:0] QLim = QW'(1 << FracBits);

  typedef logic [StatW-1:0] stat_t;
  localparam stat_t StOk  = 2'd0;
  localparam stat_t StCnt = 2'd1;
  localparam stat_t StSum = 2'd2;

  typedef logic [3:0] op_t;
  localparam op_t OpNop  = 4'd0;
  localparam op_t OpWait = 4'd1;   // wait for input transfer, latch item
  localparam op_t OpMulD = 4'd2;   // new * ref for one lane
  localparam op_t OpMulS = 4'd3;   // a * a for one lane
  localparam op_t OpUpd  = 4'd4;   // align sign, update sums
  localparam op_t OpMag  = 4'd5;   // magnitudes and signs of sums
  localparam op_t OpNorm = 4'd6;   // conditional left shift by imm
  localparam op_t OpSqI  = 4'd7;   // square root init
  localparam op_t OpSqS  = 4'd8;   // square root step
  localparam op_t OpDvI  = 4'd9;   // divide init
  localparam op_t OpDvS  = 4'd10;  // divide step
  localparam op_t OpOut  = 4'd11;  // load output register

  typedef logic [2:0] cond_t;
  localparam cond_t CondNone   = 3'd0;
  localparam cond_t CondAlways = 3'd1;
  localparam cond_t CondCnt0   = 3'd2;
  localparam cond_t CondSum0   = 3'd3;
  localparam cond_t CondLoop   = 3'd4;

  typedef struct packed {
    op_t              op;
    logic [LaneW-1:0] lane;
    logic             acc_add;
    logic             acc_clr;
    logic [ImmW-1:0]  imm;
    cond_t            cond;
    logic [PcW-1:0]   target;
    stat_t            stat;
  } cw_t;

  typedef struct packed {
    cw_t  cw;
    logic en;
  } ctrl_t;

  typedef struct packed {
    logic cnt_zero;
    logic sum_zero;
    logic out_free;
  } flags_t;

  // program addresses used as jump targets
  localparam logic [PcW-1:0] PcWait   = 5'd0;
  localparam logic [PcW-1:0] PcSqS    = 5'd19;
  localparam logic [PcW-1:0] PcDvS    = 5'd21;
  localparam logic [PcW-1:0] PcErrCnt = 5'd23;
  localparam logic [PcW-1:0] PcErrSum = 5'd24;

  function automatic cw_t mk(input op_t op, input logic [LaneW-1:0] lane,
                             input logic add, input logic clr,
                             input logic [ImmW-1:0] imm, input cond_t cond,
                             input logic [PcW-1:0] tgt, input stat_t st);
    cw_t c;
    c.op      = op;
    c.lane    = lane;
    c.acc_add = add;
    c.acc_clr = clr;
    c.imm     = imm;
    c.cond    = cond;
    c.target  = tgt;
    c.stat    = st;
    return c;
  endfunction

  function automatic cw_t ucode(input logic [PcW-1:0] pc);
    cw_t c;
    case (pc)
      5'd0:  c = mk(OpWait, '0, 1'b0, 1'b1, '0, CondNone, '0, StOk);
      5'd1:  c = mk(OpMulD, LaneW'(0), 1'b0, 1'b0, '0, CondNone, '0, StOk);
      5'd2:  c = mk(OpMulD, LaneW'(1), 1'b1, 1'b0, '0, CondNone, '0, StOk);
      5'd3:  c = mk(OpMulD, LaneW'(2), 1'b1, 1'b0, '0, CondNone, '0, StOk);
      5'd4:  c = mk(OpMulD, LaneW'(3), 1'b1, 1'b0, '0, CondNone, '0, StOk);
      5'd5:  c = mk(OpNop,  '0, 1'b1, 1'b0, '0, CondNone, '0, StOk);
      5'd6:  c = mk(OpUpd,  '0, 1'b0, 1'b0, '0, CondNone, '0, StOk);
      5'd7:  c = mk(OpMag,  '0, 1'b0, 1'b1, '0, CondCnt0, PcErrCnt, StOk);
      5'd8:  c = mk(OpNorm, '0, 1'b0, 1'b0, ImmW'(16), CondSum0, PcErrSum, StOk);
      5'd9:  c = mk(OpNorm, '0, 1'b0, 1'b0, ImmW'(8), CondNone, '0, StOk);
      5'd10: c = mk(OpNorm, '0, 1'b0, 1'b0, ImmW'(4), CondNone, '0, StOk);
      5'd11: c = mk(OpNorm, '0, 1'b0, 1'b0, ImmW'(2), CondNone, '0, StOk);
      5'd12: c = mk(OpNorm, '0, 1'b0, 1'b0, ImmW'(1), CondNone, '0, StOk);
      5'd13: c = mk(OpMulS, LaneW'(0), 1'b0, 1'b0, '0, CondNone, '0, StOk);
      5'd14: c = mk(OpMulS, LaneW'(1), 1'b1, 1'b0, '0, CondNone, '0, StOk);
      5'd15: c = mk(OpMulS, LaneW'(2), 1'b1, 1'b0, '0, CondNone, '0, StOk);
      5'd16: c = mk(OpMulS, LaneW'(3), 1'b1, 1'b0, '0, CondNone, '0, StOk);
      5'd17: c = mk(OpNop,  '0, 1'b1, 1'b0, '0, CondNone, '0, StOk);
      5'd18: c = mk(OpSqI,  '0, 1'b0, 1'b0, ImmW'(SqrtIters), CondNone, '0, StOk);
      5'd19: c = mk(OpSqS,  '0, 1'b0, 1'b0, '0, CondLoop, PcSqS, StOk);
      5'd20: c = mk(OpDvI,  '0, 1'b0, 1'b0, ImmW'(DivIters), CondNone, '0, StOk);
      5'd21: c = mk(OpDvS,  '0, 1'b0, 1'b0, '0, CondLoop, PcDvS, StOk);
      5'd22: c = mk(OpOut,  '0, 1'b0, 1'b0, '0, CondAlways, PcWait, StOk);
      5'd23: c = mk(OpOut,  '0, 1'b0, 1'b0, '0, CondAlways, PcWait, StCnt);
      5'd24: c = mk(OpOut,  '0, 1'b0, 1'b0, '0, CondAlways, PcWait, StSum);
      default: c = mk(OpNop, '0, 1'b0, 1'b0, '0, CondAlways, PcWait, StOk);
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/rqa_seq.sv
// ----------------------------------------------------------------------------
// rqa_seq: microprogram sequencer
// Step counter, loop counter and conditional jumps over the control ROM.
// ----------------------------------------------------------------------------
module rqa_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  rqa_pkg::flags_t flags_i,
  output rqa_pkg::ctrl_t  ctrl_o,
  output logic            in_ready_o
);

  logic [rqa_pkg::PcW-1:0]  pc_q, pc_d;
  logic [rqa_pkg::ImmW-1:0] iter_q, iter_d;
  rqa_pkg::cw_t             cw;
  logic                     hold;
  logic                     taken;
  logic                     en;

  assign cw = rqa_pkg::ucode(pc_q);

  always_comb begin
    case (cw.op)
      rqa_pkg::OpWait: hold = !in_valid_i;
      rqa_pkg::OpOut:  hold = !flags_i.out_free;
      default:         hold = 1'b0;
    endcase
  end

  assign en = !hold;

  always_comb begin
    case (cw.cond)
      rqa_pkg::CondAlways: taken = 1'b1;
      rqa_pkg::CondCnt0:   taken = flags_i.cnt_zero;
      rqa_pkg::CondSum0:   taken = flags_i.sum_zero;
      rqa_pkg::CondLoop:   taken = (iter_q != '0);
      default:             taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_d   = pc_q;
    iter_d = iter_q;
    if (en) begin
      pc_d = taken ? cw.target : pc_q + 1'b1;
      if (cw.op == rqa_pkg::OpSqI || cw.op == rqa_pkg::OpDvI) begin
        iter_d = cw.imm;
      end else if (cw.cond == rqa_pkg::CondLoop && iter_q != '0) begin
        iter_d = iter_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= rqa_pkg::PcWait;
      iter_q <= '0;
    end else begin
      pc_q   <= pc_d;
      iter_q <= iter_d;
    end
  end

  assign ctrl_o.cw = cw;
  assign ctrl_o.en = en;
  assign in_ready_o = (cw.op == rqa_pkg::OpWait);

endmodule

FILE: rtl/core/rqa_dp.sv
// ----------------------------------------------------------------------------
// rqa_dp: datapath
// Shared multiplier and accumulator, four sum lanes, normalizer, bit-serial
// square root, four bit-serial dividers and the output register.
// ----------------------------------------------------------------------------
module rqa_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rqa_pkg::ctrl_t                     ctrl_i,
  output rqa_pkg::flags_t                    flags_o,
  input  logic signed [rqa_pkg::NewW-1:0]    new_w_i,
  input  logic signed [rqa_pkg::NewW-1:0]    new_x_i,
  input  logic signed [rqa_pkg::NewW-1:0]    new_y_i,
  input  logic signed [rqa_pkg::NewW-1:0]    new_z_i,
  input  logic signed [rqa_pkg::NewW-1:0]    ref_w_i,
  input  logic signed [rqa_pkg::NewW-1:0]    ref_x_i,
  input  logic signed [rqa_pkg::NewW-1:0]    ref_y_i,
  input  logic signed [rqa_pkg::NewW-1:0]    ref_z_i,
  input  logic        [rqa_pkg::CntW-1:0]    sample_count_i,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [rqa_pkg::NewW-1:0]    avg_w_o,
  output logic signed [rqa_pkg::NewW-1:0]    avg_x_o,
  output logic signed [rqa_pkg::NewW-1:0]    avg_y_o,
  output logic signed [rqa_pkg::NewW-1:0]    avg_z_o,
  output logic        [rqa_pkg::StatW-1:0]   status_o
);

  localparam int NewW  = rqa_pkg::NewW;
  localparam int SumW  = rqa_pkg::SumW;
  localparam int OpW   = rqa_pkg::OpW;
  localparam int ProdW = rqa_pkg::ProdW;
  localparam int RootW = rqa_pkg::RootW;
  localparam int RemW  = rqa_pkg::RemW;
  localparam int QW    = rqa_pkg::QW;
  localparam int NumW  = rqa_pkg::NumW;
  localparam int Lanes = rqa_pkg::Lanes;

  rqa_pkg::cw_t cw;
  logic         en;

  // latched item
  logic signed [NewW-1:0]         new_q [Lanes];
  logic signed [NewW-1:0]         ref_q [Lanes];
  logic [rqa_pkg::CntW-1:0]       cnt_q;
  logic                           rst_sum_q;

  // kept state
  logic signed [SumW-1:0]         sum_q [Lanes];

  // multiply-accumulate
  logic signed [OpW-1:0]          op_a, op_b;
  logic signed [ProdW-1:0]        prod, prod_q, acc_q;

  // normalized magnitudes
  logic [SumW-1:0]                a_q [Lanes];
  logic                           sgn_q [Lanes];
  logic [SumW-1:0]                or_a;
  logic [rqa_pkg::ImmW-1:0]       rsh;
  logic                           do_shift;

  // square root
  logic [ProdW-1:0]               nsh_q;
  logic [RemW-1:0]                rem_q;
  logic [RootW-1:0]               root_q;
  logic [RemW+1:0]                rem2, trial;
  logic                           sq_ge;

  // dividers
  logic [RemW-1:0]                dr_q [Lanes];
  logic [QW-1:0]                  dq_q [Lanes];
  logic [RemW:0]                  r2 [Lanes];
  logic [RemW:0]                  dd;
  logic                           dv_ge [Lanes];
  logic [NumW-1:0]                num [Lanes];

  // lane arithmetic
  logic signed [NewW:0]           qa [Lanes];
  logic signed [SumW:0]           t [Lanes];
  logic signed [SumW-1:0]         sum_n [Lanes];
  logic [SumW-1:0]                mag [Lanes];
  logic [QW-1:0]                  vc [Lanes];
  logic signed [NewW-1:0]         res [Lanes];
  logic                           dot_neg;

  // output register
  logic signed [NewW-1:0]         avg_q [Lanes];
  rqa_pkg::stat_t                 stat_q;
  logic                           oval_q;

  assign cw = ctrl_i.cw;
  assign en = ctrl_i.en;

  // shared multiplier
  always_comb begin
    if (cw.op == rqa_pkg::OpMulS) begin
      op_a = signed'({1'b0, a_q[cw.lane]});
      op_b = signed'({1'b0, a_q[cw.lane]});
    end else begin
      op_a = OpW'(new_q[cw.lane]);
      op_b = OpW'(ref_q[cw.lane]);
    end
  end

  assign prod    = op_a * op_b;
  assign dot_neg = acc_q[ProdW-1];

  always_comb begin
    or_a = '0;
    for (int i = 0; i < Lanes; i++) begin
      or_a = or_a | a_q[i];
    end
  end

  // shift by imm only while the largest magnitude stays below the top bit
  assign rsh      = rqa_pkg::ImmW'(SumW - 1) - cw.imm;
  assign do_shift = ((or_a >> rsh) == '0);

  assign rem2  = {rem_q, nsh_q[ProdW-1 -: 2]};
  assign trial = (RemW + 2)'({root_q, 2'b01});
  assign sq_ge = (rem2 >= trial);
  assign dd    = (RemW + 1)'({root_q, 1'b0});

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      qa[i]    = dot_neg ? -(NewW + 1)'(new_q[i]) : (NewW + 1)'(new_q[i]);
      t[i]     = (rst_sum_q ? '0 : (SumW + 1)'(sum_q[i])) + (SumW + 1)'(qa[i]);
      if (t[i][SumW] != t[i][SumW-1]) begin
        sum_n[i] = t[i][SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
      end else begin
        sum_n[i] = t[i][SumW-1:0];
      end
      mag[i]   = sum_q[i][SumW-1] ? SumW'(-sum_q[i]) : SumW'(sum_q[i]);
      num[i]   = {a_q[i], {QW{1'b0}}} + NumW'(root_q);
      r2[i]    = {dr_q[i], dq_q[i][QW-1]};
      dv_ge[i] = (r2[i] >= dd);
      vc[i]    = (dq_q[i] > rqa_pkg::QLim) ? rqa_pkg::QLim : dq_q[i];
      res[i]   = sgn_q[i] ? -NewW'(vc[i]) : NewW'(vc[i]);
    end
  end

  // item latch and working registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      case (cw.op)
        rqa_pkg::OpWait: begin
          new_q[0]  <= new_w_i;
          new_q[1]  <= new_x_i;
          new_q[2]  <= new_y_i;
          new_q[3]  <= new_z_i;
          ref_q[0]  <= ref_w_i;
          ref_q[1]  <= ref_x_i;
          ref_q[2]  <= ref_y_i;
          ref_q[3]  <= ref_z_i;
          cnt_q     <= sample_count_i;
          rst_sum_q <= restart_i;
        end
        rqa_pkg::OpMulD, rqa_pkg::OpMulS: begin
          prod_q <= prod;
        end
        rqa_pkg::OpMag: begin
          for (int i = 0; i < Lanes; i++) begin
            a_q[i]   <= mag[i];
            sgn_q[i] <= sum_q[i][SumW-1];
          end
        end
        rqa_pkg::OpNorm: begin
          if (do_shift) begin
            for (int i = 0; i < Lanes; i++) begin
              a_q[i] <= a_q[i] << cw.imm;
            end
          end
        end
        rqa_pkg::OpSqI: begin
          nsh_q  <= acc_q;
          rem_q  <= '0;
          root_q <= '0;
        end
        rqa_pkg::OpSqS: begin
          nsh_q <= nsh_q << 2;
          if (sq_ge) begin
            rem_q  <= RemW'(rem2 - trial);
            root_q <= {root_q[RootW-2:0], 1'b1};
          end else begin
            rem_q  <= RemW'(rem2);
            root_q <= {root_q[RootW-2:0], 1'b0};
          end
        end
        rqa_pkg::OpDvI: begin
          for (int i = 0; i < Lanes; i++) begin
            dr_q[i] <= RemW'(num[i][NumW-1:QW]);
            dq_q[i] <= num[i][QW-1:0];
          end
        end
        rqa_pkg::OpDvS: begin
          for (int i = 0; i < Lanes; i++) begin
            dr_q[i] <= dv_ge[i] ? RemW'(r2[i] - dd) : RemW'(r2[i]);
            dq_q[i] <= {dq_q[i][QW-2:0], dv_ge[i]};
          end
        end
        default: ;
      endcase
      if (cw.acc_clr) begin
        acc_q <= '0;
      end else if (cw.acc_add) begin
        acc_q <= acc_q + prod_q;
      end
    end
  end

  // kept sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lanes; i++) begin
        sum_q[i] <= '0;
      end
    end else if (en && cw.op == rqa_pkg::OpUpd) begin
      for (int i = 0; i < Lanes; i++) begin
        sum_q[i] <= sum_n[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (en && cw.op == rqa_pkg::OpOut) begin
      oval_q <= 1'b1;
    end else if (out_ready_i) begin
      oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && cw.op == rqa_pkg::OpOut) begin
      stat_q <= cw.stat;
      for (int i = 0; i < Lanes; i++) begin
        avg_q[i] <= (cw.stat == rqa_pkg::StOk) ? res[i] : '0;
      end
    end
  end

  assign flags_o.cnt_zero = (cnt_q == '0);
  assign flags_o.sum_zero = (or_a == '0);
  assign flags_o.out_free = !oval_q || out_ready_i;

  assign out_valid_o = oval_q;
  assign avg_w_o     = avg_q[0];
  assign avg_x_o     = avg_q[1];
  assign avg_y_o     = avg_q[2];
  assign avg_z_o     = avg_q[3];
  assign status_o    = stat_q;

endmodule

FILE: rtl/core/running_quaternion_average_top.sv
// ----------------------------------------------------------------------------
// running_quaternion_average_top: running quaternion average
// Sign-aligns each new quaternion against a reference, adds it into four
// saturating Q12.14 sums and returns the sum scaled to unit length.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   new_*, ref_*, sample_count, restart
//   out      output     out_valid_o / out_ready_i avg_*, status
//
// One item is worked on at a time by a microcoded sequencer. The next
// transfer can happen only once the item is finished; the 28-step square
// root loop and the 15-step divide loop make up most of that work.
// A zero count or a zero sum ends the item early with an error status.
// Reset clears the sums, the step counter and the output valid.
// A waiting result stalls only the final step; the next item is taken while
// the result register is still full.
// ----------------------------------------------------------------------------
module running_quaternion_average_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [rqa_pkg::NewW-1:0]    new_w_i,
  input  logic signed [rqa_pkg::NewW-1:0]    new_x_i,
  input  logic signed [rqa_pkg::NewW-1:0]    new_y_i,
  input  logic signed [rqa_pkg::NewW-1:0]    new_z_i,
  input  logic signed [rqa_pkg::NewW-1:0]    ref_w_i,
  input  logic signed [rqa_pkg::NewW-1:0]    ref_x_i,
  input  logic signed [rqa_pkg::NewW-1:0]    ref_y_i,
  input  logic signed [rqa_pkg::NewW-1:0]    ref_z_i,
  input  logic        [rqa_pkg::CntW-1:0]    sample_count_i,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [rqa_pkg::NewW-1:0]    avg_w_o,
  output logic signed [rqa_pkg::NewW-1:0]    avg_x_o,
  output logic signed [rqa_pkg::NewW-1:0]    avg_y_o,
  output logic signed [rqa_pkg::NewW-1:0]    avg_z_o,
  output logic        [rqa_pkg::StatW-1:0]   status_o
);

  rqa_pkg::ctrl_t  ctrl;
  rqa_pkg::flags_t flags;

  // sequencer: ROM walk, loop counts, jumps on count/sum zero
  rqa_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .flags_i    (flags),
    .ctrl_o     (ctrl),
    .in_ready_o (in_ready_o)
  );

  // datapath: sums, multiplier, root, dividers, result register
  rqa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .flags_o        (flags),
    .new_w_i        (new_w_i),
    .new_x_i        (new_x_i),
    .new_y_i        (new_y_i),
    .new_z_i        (new_z_i),
    .ref_w_i        (ref_w_i),
    .ref_x_i        (ref_x_i),
    .ref_y_i        (ref_y_i),
    .ref_z_i        (ref_z_i),
    .sample_count_i (sample_count_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .avg_w_o        (avg_w_o),
    .avg_x_o        (avg_x_o),
    .avg_y_o        (avg_y_o),
    .avg_z_o        (avg_z_o),
    .status_o       (status_o)
  );

`ifndef SYNTHESIS
  // one item at a time: an input transfer closes the input side
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  // error results carry zero components
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != rqa_pkg::StOk |->
      avg_w_o == '0 && avg_x_o == '0 && avg_y_o == '0 && avg_z_o == '0)
    else $error("error status with nonzero components");

  // only defined status codes leave the block
  a_stat_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == rqa_pkg::StOk || status_o == rqa_pkg::StCnt ||
                    status_o == rqa_pkg::StSum)
    else $error("undefined status code");
`endif

endmodule
